FILE: hw/rtl/smt_pkg.sv
// Shared package for the set membership table.
// Holds the beat types, operation and status codes and default sizes.
// Depends on nothing.
`timescale 1ns / 1ps

package smt_pkg;

  localparam int SMT_CAPACITY  = 64;
  localparam int SMT_ELEM_BITS = 32;
  localparam int ELEMENT_W     = 32;
  localparam int COUNT_W       = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                  operation;
    logic signed [ELEMENT_W-1:0] element;
  } smt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] element_count;
    logic               is_empty;
  } smt_out_t;

  typedef struct packed {
    logic    exec;
    smt_in_t item;
  } smt_req_t;

endpackage

FILE: hw/rtl/smt_store.sv
// Element store of the set membership table: slots, occupied marks and count.
// Compares the key against all slots at once and applies the update.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_store #(
  parameter int CAPACITY  = smt_pkg::SMT_CAPACITY,
  parameter int ELEM_BITS = smt_pkg::SMT_ELEM_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smt_pkg::smt_req_t req,
  output smt_pkg::smt_out_t result
);
  import smt_pkg::*;

  localparam int KEY_BITS = (ELEM_BITS < ELEMENT_W) ? ELEM_BITS : ELEMENT_W;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0] entry_values_r [CAPACITY];
  logic [CAPACITY-1:0] entry_valid_r;
  logic [CAPACITY-1:0] entry_valid_nxt;
  logic [CNT_W-1:0]    entry_count_r;
  logic [CNT_W-1:0]    entry_count_nxt;

  logic [KEY_BITS-1:0] key;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] free_vec;
  logic [CAPACITY-1:0] free_pick;
  logic                hit;
  logic                full;
  logic                do_add;
  logic                do_rem;
  logic [1:0]          status;

  assign key = req.item.element[KEY_BITS-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = entry_valid_r[i] && (entry_values_r[i] == key);
    end
  end

  assign hit       = |match;
  assign full      = (entry_count_r >= CNT_W'(CAPACITY));
  assign free_vec  = ~entry_valid_r;
  assign free_pick = free_vec & (~free_vec + CAPACITY'(1));

  assign do_add = req.exec && (req.item.operation == OP_ADD) && !hit && !full;
  assign do_rem = req.exec && (req.item.operation == OP_REMOVE) && hit;

  always_comb begin
    case (req.item.operation)
      OP_ADD:    status = hit ? ST_MISS : (full ? ST_FULL : ST_DONE);
      OP_REMOVE: status = hit ? ST_DONE : ST_MISS;
      default:   status = hit ? ST_DONE : ST_MISS;
    endcase
  end

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    entry_count_nxt = entry_count_r;
    if (do_add) begin
      entry_valid_nxt = entry_valid_r | free_pick;
      entry_count_nxt = entry_count_r + CNT_W'(1);
    end else if (do_rem) begin
      entry_valid_nxt = entry_valid_r & ~match;
      entry_count_nxt = entry_count_r - CNT_W'(1);
    end
  end

  assign result.status        = status;
  assign result.element_count = COUNT_W'(entry_count_nxt);
  assign result.is_empty      = (entry_count_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      entry_count_r <= '0;
    end else begin
      entry_valid_r <= entry_valid_nxt;
      entry_count_r <= entry_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_add && free_pick[i]) begin
        entry_values_r[i] <= key;
      end
    end
  end

endmodule

FILE: hw/rtl/set_membership_table.sv
// The set membership table keeps up to CAPACITY distinct element values and
// takes one add, remove or search beat per clock while in_stall is low. Each
// accepted beat yields one result beat: it waits in the input register, is
// compared against every slot as the store updates, and the outcome lands in
// the output register. The throughput of one beat per cycle, held by out_stall,
// is set by that parallel compare; the output register lets a new beat enter
// while a finished result waits. No clearing pass is needed after reset.
// Depends on smt_pkg and smt_store.
`timescale 1ns / 1ps

module set_membership_table #(
  parameter int CAPACITY  = smt_pkg::SMT_CAPACITY,
  parameter int ELEM_BITS = smt_pkg::SMT_ELEM_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  smt_pkg::smt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output smt_pkg::smt_out_t out_data
);
  import smt_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  smt_in_t  s1_item_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  smt_out_t out_data_r;
  logic     advance;
  logic     accept;
  smt_req_t req;
  smt_out_t result;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign req.exec = s1_valid_r && advance;
  assign req.item = s1_item_r;

  smt_store #(
    .CAPACITY  (CAPACITY),
    .ELEM_BITS (ELEM_BITS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .result (result)
  );

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (req.exec) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/smt_checker.sv
// Port-level checks for the set membership table, bound to the top level.
// Depends on smt_pkg and set_membership_table.
`timescale 1ns / 1ps

module smt_checker #(
  parameter int CAPACITY = smt_pkg::SMT_CAPACITY
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input smt_pkg::smt_out_t out_data
);
  import smt_pkg::*;

  logic [COUNT_W-1:0] cap_count;
  assign cap_count = COUNT_W'(CAPACITY);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side can move");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed or vanished");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |->
      ((out_data.element_count == cap_count) && !out_data.is_empty))
    else $error("full status without a full count");

  a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$isunknown(in_stall))
    else $error("stall unknown after an accepted beat");

endmodule

bind set_membership_table smt_checker #(.CAPACITY(CAPACITY)) u_smt_checker (.*);
